@@ rtl/dreq_pkg.sv @@
// Shared types and constants of the disk request scheduler.
// Used by the datapath, controller and top of the block; depends on nothing.
package dreq_pkg;

  // Default geometry and queue size
  localparam int DEF_QUEUE_DEPTH         = 16;
  localparam int DEF_SECTORS_PER_TRACK   = 32;
  localparam int DEF_TRACKS_PER_CYLINDER = 19;

  // Fixed field widths
  localparam int NUM_SLICES = 8;
  localparam int SLICE_W    = 3;
  localparam int CFG_W      = 48;
  localparam int BLOCK_W    = 32;
  localparam int LAST_W     = 24;
  localparam int CYL_W      = 16;
  localparam int TRK_W      = 5;
  localparam int SEC_W      = 5;
  localparam int TAG_W      = 8;
  localparam int BCNT_W     = 16;
  localparam int STAT_W     = 3;
  localparam int QCNT_W     = 5;
  localparam int ACC_W      = 3;
  localparam int DCNT_W     = 6;
  localparam int ENTRY_W    = TAG_W + 1 + SEC_W + TRK_W + CYL_W;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_END_READ = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DEQUEUED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic set_empty;
    logic set_reject;
    logic deq_rd;
    logic deq_commit;
    logic div1_init;
    logic div2_init;
    logic div_step;
    logic write_entry;
    logic ap_load;
    logic cp_step;
    logic link1;
    logic link2;
    logic out_load;
  } dreq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_deq;
    logic q_empty;
    logic reject;
    logic div_last;
    logic nx_nil;
    logic closer;
  } dreq_stat_t;

endpackage

@@ rtl/dreq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dreq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dreq_dp.sv @@
// Datapath of the disk request scheduler: slice registers, reciprocal divider,
// queue pointers, entry memories and result registers. Uses dreq_pkg, dreq_ram.
module dreq_dp #(
  parameter int QUEUE_DEPTH         = dreq_pkg::DEF_QUEUE_DEPTH,
  parameter int SECTORS_PER_TRACK   = dreq_pkg::DEF_SECTORS_PER_TRACK,
  parameter int TRACKS_PER_CYLINDER = dreq_pkg::DEF_TRACKS_PER_CYLINDER
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dreq_pkg::SLICE_W-1:0]     cfg_index,
  input  logic [dreq_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_cmd,
  input  logic [dreq_pkg::SLICE_W-1:0]     in_slice,
  input  logic signed [dreq_pkg::BLOCK_W-1:0] in_block,
  input  logic                             in_is_read,
  input  logic [dreq_pkg::TAG_W-1:0]       in_tag,
  input  logic [dreq_pkg::BCNT_W-1:0]      in_byte_count,
  input  dreq_pkg::dreq_cmd_t              cmd,
  output dreq_pkg::dreq_stat_t             stat,
  output logic [dreq_pkg::STAT_W-1:0]      out_status,
  output logic [dreq_pkg::TAG_W-1:0]       out_tag,
  output logic [dreq_pkg::CYL_W-1:0]       out_cylinder,
  output logic [dreq_pkg::TRK_W-1:0]       out_track,
  output logic [dreq_pkg::SEC_W-1:0]       out_sector,
  output logic                             out_read,
  output logic [dreq_pkg::BCNT_W-1:0]      out_residual,
  output logic [dreq_pkg::QCNT_W-1:0]      out_queue_count
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int IDX_W   = ADDR_W + 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PER_CYL = SECTORS_PER_TRACK * TRACKS_PER_CYLINDER;
  localparam int RW      = $clog2(PER_CYL) + 1;
  localparam int XW      = dreq_pkg::LAST_W;
  localparam int PW      = 2 * XW + 1;
  localparam int QW      = XW + RW + 1;
  localparam logic [IDX_W-1:0] NIL = {IDX_W{1'b1}};
  localparam logic [RW:0] DIV_CYL = (RW+1)'(PER_CYL);
  localparam logic [RW:0] DIV_TRK = (RW+1)'(SECTORS_PER_TRACK);
  localparam logic [XW:0] REC_CYL = (XW+1)'((1 << XW) / PER_CYL);
  localparam logic [XW:0] REC_TRK = (XW+1)'((1 << XW) / SECTORS_PER_TRACK);

  // Divider step codes, counted down
  localparam logic [dreq_pkg::DCNT_W-1:0] DST_MUL = dreq_pkg::DCNT_W'(4);
  localparam logic [dreq_pkg::DCNT_W-1:0] DST_QUO = dreq_pkg::DCNT_W'(3);
  localparam logic [dreq_pkg::DCNT_W-1:0] DST_REM = dreq_pkg::DCNT_W'(2);
  localparam logic [dreq_pkg::DCNT_W-1:0] DST_FIX = dreq_pkg::DCNT_W'(1);

  // Slice registers
  logic [dreq_pkg::CYL_W-1:0]  offset_r [dreq_pkg::NUM_SLICES];
  logic [dreq_pkg::LAST_W-1:0] last_r   [dreq_pkg::NUM_SLICES];

  // Captured request
  logic                            cmd_r;
  logic [dreq_pkg::SLICE_W-1:0]    slice_r;
  logic [dreq_pkg::BLOCK_W-1:0]    block_r;
  logic                            rd_r;
  logic [dreq_pkg::TAG_W-1:0]      tag_r;
  logic [dreq_pkg::BCNT_W-1:0]     bcnt_r;

  // Divider
  logic [XW-1:0]                x_r;
  logic [XW-1:0]                q_r;
  logic [RW-1:0]                rem_r;
  logic [PW-1:0]                prod_r;
  logic [dreq_pkg::DCNT_W-1:0]  dcnt_r;
  logic                         dsel_r;
  logic [RW:0]                  divisor;
  logic [XW:0]                  recip;
  logic [PW-1:0]                mul_p;
  logic [QW-1:0]                qd_p;
  logic [XW-1:0]                rem_full;
  logic                         rem_ge;

  // Queue state
  logic [QUEUE_DEPTH-1:0] free_r;
  logic [IDX_W-1:0]       head_r, tail_r, scan_r;
  logic [dreq_pkg::ACC_W-1:0] acc_r;
  logic [CNT_W-1:0]       pend_r;

  // Walk registers
  logic [IDX_W-1:0]           n_r, ap_r, cp_r;
  logic [dreq_pkg::CYL_W-1:0] cyl_n_r, cyl_ap_r;
  logic [dreq_pkg::TRK_W-1:0] trk_n;
  logic [dreq_pkg::SEC_W-1:0] sec_n;

  // Result holding registers
  logic [dreq_pkg::STAT_W-1:0] res_status_r;
  logic [dreq_pkg::TAG_W-1:0]  res_tag_r;
  logic [dreq_pkg::CYL_W-1:0]  res_cyl_r;
  logic [dreq_pkg::TRK_W-1:0]  res_trk_r;
  logic [dreq_pkg::SEC_W-1:0]  res_sec_r;
  logic                        res_rd_r;
  logic [dreq_pkg::BCNT_W-1:0] res_resid_r;

  // Memory ports
  logic                        d_we, n_we;
  logic [ADDR_W-1:0]           d_waddr, n_waddr, raddr;
  logic [dreq_pkg::ENTRY_W-1:0] d_wdata, d_rdata;
  logic [IDX_W-1:0]            n_wdata, n_rdata;
  logic [IDX_W-1:0]            raddr_idx;

  // Decoded read entry
  logic [dreq_pkg::CYL_W-1:0]  rd_cyl;
  logic [dreq_pkg::TRK_W-1:0]  rd_trk;
  logic [dreq_pkg::SEC_W-1:0]  rd_sec;
  logic                        rd_rd;
  logic [dreq_pkg::TAG_W-1:0]  rd_tag;

  // Misc combinational
  logic [IDX_W-1:0]            free_idx;
  logic                        full;
  logic                        neg, bad, end_rd;
  logic [dreq_pkg::BLOCK_W-1:0] last_ext;
  logic [dreq_pkg::ACC_W-1:0]  acc_nxt;
  logic [IDX_W-1:0]            scan_eff, ap_new;
  logic [dreq_pkg::CYL_W-1:0]  d_an, d_ac;
  logic [31:0]                 rem_wide, pend_wide;

  dreq_ram #(.WIDTH(dreq_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(raddr), .rdata(d_rdata)
  );

  dreq_ram #(.WIDTH(IDX_W), .DEPTH(QUEUE_DEPTH)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(raddr), .rdata(n_rdata)
  );

  assign {rd_tag, rd_rd, rd_sec, rd_trk, rd_cyl} = d_rdata;

  // Find the lowest free slot
  always_comb begin
    free_idx = NIL;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end
  assign full = (free_r == '0);

  // Range check against the slice size
  assign last_ext = dreq_pkg::BLOCK_W'(last_r[slice_r]);
  assign neg      = block_r[dreq_pkg::BLOCK_W-1];
  assign bad      = neg || (block_r >= last_ext);
  assign end_rd   = !neg && (block_r == last_ext) && rd_r;

  // Reciprocal estimate, back-multiply and a single correction step
  assign divisor  = dsel_r ? DIV_TRK : DIV_CYL;
  assign recip    = dsel_r ? REC_TRK : REC_CYL;
  assign mul_p    = PW'(x_r) * PW'(recip);
  assign qd_p     = QW'(q_r) * QW'(divisor);
  assign rem_full = x_r - qd_p[XW-1:0];
  assign rem_ge   = ({1'b0, rem_r} >= divisor);

  // Track and sector after the second division
  assign rem_wide = 32'(rem_r);
  assign trk_n    = q_r[dreq_pkg::TRK_W-1:0];
  assign sec_n    = rem_wide[dreq_pkg::SEC_W-1:0];

  // Walk start point
  assign acc_nxt  = acc_r + 1'b1;
  assign scan_eff = (acc_nxt == '0) ? tail_r : scan_r;
  assign ap_new   = (scan_eff != NIL) ? scan_eff : head_r;

  // Cylinder distances from the current anchor
  assign d_an = (cyl_ap_r >= cyl_n_r) ? cyl_ap_r - cyl_n_r : cyl_n_r - cyl_ap_r;
  assign d_ac = (cyl_ap_r >= rd_cyl) ? cyl_ap_r - rd_cyl : rd_cyl - cyl_ap_r;

  // Read address select
  always_comb begin
    if (cmd.deq_rd) begin
      raddr_idx = head_r;
    end else if (cmd.write_entry) begin
      raddr_idx = ap_new;
    end else begin
      raddr_idx = n_rdata;
    end
  end
  assign raddr = raddr_idx[ADDR_W-1:0];

  // Memory writes
  always_comb begin
    d_we    = cmd.write_entry;
    d_waddr = n_r[ADDR_W-1:0];
    d_wdata = {tag_r, rd_r, sec_n, trk_n, cyl_n_r};
    n_we    = cmd.write_entry || cmd.link1 || cmd.link2;
    n_waddr = n_r[ADDR_W-1:0];
    n_wdata = NIL;
    if (cmd.link1) begin
      n_waddr = ap_r[ADDR_W-1:0];
      n_wdata = n_r;
    end else if (cmd.link2) begin
      n_wdata = cp_r;
    end
  end

  // Status to the controller
  assign stat.is_deq   = (cmd_r == dreq_pkg::CMD_DEQ);
  assign stat.q_empty  = (head_r == NIL);
  assign stat.reject   = bad || full;
  assign stat.div_last = (dcnt_r == DST_FIX);
  assign stat.nx_nil   = (n_rdata == NIL);
  assign stat.closer   = (d_an < d_ac);

  // Slice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dreq_pkg::NUM_SLICES; i++) begin
        offset_r[i] <= '0;
        last_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      offset_r[cfg_index] <= cfg_wdata[47:32];
      last_r[cfg_index]   <= cfg_wdata[23:0];
    end
  end

  // Queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      head_r <= NIL;
      tail_r <= NIL;
      scan_r <= NIL;
      acc_r  <= '0;
      pend_r <= '0;
    end else begin
      if (cmd.write_entry) begin
        free_r[n_r[ADDR_W-1:0]] <= 1'b0;
        acc_r  <= acc_nxt;
        pend_r <= pend_r + 1'b1;
        if (head_r == NIL) begin
          head_r <= n_r;
          tail_r <= n_r;
          scan_r <= n_r;
        end else begin
          scan_r <= scan_eff;
        end
      end
      if (cmd.link1 && (cp_r == NIL)) begin
        tail_r <= n_r;
      end
      if (cmd.deq_commit) begin
        free_r[head_r[ADDR_W-1:0]] <= 1'b1;
        pend_r <= pend_r - 1'b1;
        head_r <= n_rdata;
        if (n_rdata == NIL) begin
          tail_r <= NIL;
        end
        if (scan_r == head_r) begin
          scan_r <= n_rdata;
        end
      end
    end
  end

  // Request capture, divider and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      slice_r <= in_slice;
      block_r <= in_block;
      rd_r    <= in_is_read;
      tag_r   <= in_tag;
      bcnt_r  <= in_byte_count;
    end
    if (cmd.div1_init) begin
      x_r    <= block_r[XW-1:0];
      dcnt_r <= DST_MUL;
      dsel_r <= 1'b0;
      n_r    <= free_idx;
    end else if (cmd.div2_init) begin
      cyl_n_r <= q_r[dreq_pkg::CYL_W-1:0] + offset_r[slice_r];
      x_r     <= {{(XW-RW){1'b0}}, rem_r};
      dcnt_r  <= DST_MUL;
      dsel_r  <= 1'b1;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
      case (dcnt_r)
        DST_MUL: begin
          prod_r <= mul_p;
        end
        DST_QUO: begin
          q_r <= prod_r[XW +: XW];
        end
        DST_REM: begin
          rem_r <= RW'(rem_full);
        end
        DST_FIX: begin
          if (rem_ge) begin
            q_r   <= q_r + XW'(1);
            rem_r <= RW'({1'b0, rem_r} - divisor);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.ap_load) begin
      ap_r     <= ap_r;
      cyl_ap_r <= rd_cyl;
      cp_r     <= n_rdata;
    end else if (cmd.write_entry) begin
      ap_r <= ap_new;
    end else if (cmd.cp_step && !stat.closer) begin
      ap_r     <= cp_r;
      cyl_ap_r <= rd_cyl;
      cp_r     <= n_rdata;
    end
  end

  // Result selection
  always_ff @(posedge clk) begin
    if (cmd.set_empty) begin
      res_status_r <= dreq_pkg::ST_EMPTY;
      res_tag_r    <= '0;
      res_cyl_r    <= '0;
      res_trk_r    <= '0;
      res_sec_r    <= '0;
      res_rd_r     <= 1'b0;
      res_resid_r  <= '0;
    end else if (cmd.set_reject) begin
      res_status_r <= !bad ? dreq_pkg::ST_FULL :
                      end_rd ? dreq_pkg::ST_END_READ : dreq_pkg::ST_RANGE;
      res_tag_r    <= tag_r;
      res_cyl_r    <= '0;
      res_trk_r    <= '0;
      res_sec_r    <= '0;
      res_rd_r     <= 1'b0;
      res_resid_r  <= (bad && end_rd) ? bcnt_r : '0;
    end else if (cmd.deq_commit) begin
      res_status_r <= dreq_pkg::ST_DEQUEUED;
      res_tag_r    <= rd_tag;
      res_cyl_r    <= rd_cyl;
      res_trk_r    <= rd_trk;
      res_sec_r    <= rd_sec;
      res_rd_r     <= rd_rd;
      res_resid_r  <= '0;
    end else if (cmd.write_entry) begin
      res_status_r <= dreq_pkg::ST_QUEUED;
      res_tag_r    <= tag_r;
      res_cyl_r    <= cyl_n_r;
      res_trk_r    <= trk_n;
      res_sec_r    <= sec_n;
      res_rd_r     <= rd_r;
      res_resid_r  <= '0;
    end
  end

  // Output register
  assign pend_wide = 32'(pend_r);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_tag         <= res_tag_r;
      out_cylinder    <= res_cyl_r;
      out_track       <= res_trk_r;
      out_sector      <= res_sec_r;
      out_read        <= res_rd_r;
      out_residual    <= res_resid_r;
      out_queue_count <= pend_wide[dreq_pkg::QCNT_W-1:0];
    end
  end

endmodule

@@ rtl/dreq_ctrl.sv @@
// Controller of the disk request scheduler: sequences check, division,
// insertion walk, dequeue and result handoff. Uses dreq_pkg.
module dreq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  dreq_pkg::dreq_stat_t stat,
  output dreq_pkg::dreq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV1, S_DIV2_INIT, S_DIV2, S_WRITE, S_AP_LOAD,
    S_CP_LOAD, S_LINK1, S_LINK2, S_DEQ_LOAD, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_deq) begin
          if (stat.q_empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = S_FINISH;
          end else begin
            cmd.deq_rd = 1'b1;
            state_nxt  = S_DEQ_LOAD;
          end
        end else if (stat.reject) begin
          cmd.set_reject = 1'b1;
          state_nxt      = S_FINISH;
        end else begin
          cmd.div1_init = 1'b1;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DIV2_INIT;
        end
      end
      S_DIV2_INIT: begin
        cmd.div2_init = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_nxt       = stat.q_empty ? S_FINISH : S_AP_LOAD;
      end
      S_AP_LOAD: begin
        cmd.ap_load = 1'b1;
        state_nxt   = stat.nx_nil ? S_LINK1 : S_CP_LOAD;
      end
      S_CP_LOAD: begin
        cmd.cp_step = 1'b1;
        if (stat.closer || stat.nx_nil) begin
          state_nxt = S_LINK1;
        end
      end
      S_LINK1: begin
        cmd.link1 = 1'b1;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        cmd.link2 = 1'b1;
        state_nxt = S_FINISH;
      end
      S_DEQ_LOAD: begin
        cmd.deq_commit = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when the beat is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result beat overwritten while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted while busy");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside finish");
`endif

endmodule

@@ rtl/disk_request_scheduler.sv @@
// Disk request scheduler: one item at a time. Each division takes four steps (reciprocal
// multiply, quotient take, back-multiply for the remainder, one correction); the link
// walk reads one entry per cycle. A stalled result holds off the next accept.
// Synchronous active-low reset empties the queue and clears slices.
module disk_request_scheduler #(
  parameter int QUEUE_DEPTH         = dreq_pkg::DEF_QUEUE_DEPTH,
  parameter int SECTORS_PER_TRACK   = dreq_pkg::DEF_SECTORS_PER_TRACK,
  parameter int TRACKS_PER_CYLINDER = dreq_pkg::DEF_TRACKS_PER_CYLINDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dreq_pkg::SLICE_W-1:0]        cfg_index,
  input  logic [dreq_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [dreq_pkg::SLICE_W-1:0]        in_slice,
  input  logic signed [dreq_pkg::BLOCK_W-1:0] in_block,
  input  logic                                in_is_read,
  input  logic [dreq_pkg::TAG_W-1:0]          in_tag,
  input  logic [dreq_pkg::BCNT_W-1:0]         in_byte_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dreq_pkg::STAT_W-1:0]         out_status,
  output logic [dreq_pkg::TAG_W-1:0]          out_tag,
  output logic [dreq_pkg::CYL_W-1:0]          out_cylinder,
  output logic [dreq_pkg::TRK_W-1:0]          out_track,
  output logic [dreq_pkg::SEC_W-1:0]          out_sector,
  output logic                                out_read,
  output logic [dreq_pkg::BCNT_W-1:0]         out_residual,
  output logic [dreq_pkg::QCNT_W-1:0]         out_queue_count
);

  dreq_pkg::dreq_cmd_t  cmd;
  dreq_pkg::dreq_stat_t stat;

  dreq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  dreq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SECTORS_PER_TRACK(SECTORS_PER_TRACK),
    .TRACKS_PER_CYLINDER(TRACKS_PER_CYLINDER)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_cmd(in_cmd), .in_slice(in_slice), .in_block(in_block),
    .in_is_read(in_is_read), .in_tag(in_tag), .in_byte_count(in_byte_count),
    .cmd(cmd), .stat(stat),
    .out_status(out_status), .out_tag(out_tag), .out_cylinder(out_cylinder),
    .out_track(out_track), .out_sector(out_sector), .out_read(out_read),
    .out_residual(out_residual), .out_queue_count(out_queue_count)
  );

endmodule

@@ sim/disk_request_scheduler_tb.sv @@
// Testbench for the disk request scheduler: directed and random enqueue/dequeue beats,
// with a cycle-free queue model in a scoreboard class. Depends on dreq_pkg and the RTL.
`timescale 1ns / 100ps

module disk_request_scheduler_tb;

  localparam int DEPTH = 16;
  localparam int SPT   = 32;
  localparam int TPC   = 19;
  localparam int NIL   = 31;

  typedef struct {
    logic             cmd;
    logic [2:0]       slice;
    logic [31:0]      block;
    logic             is_read;
    logic [7:0]       tag;
    logic [15:0]      byte_count;
  } request_t;

  typedef struct {
    dreq_pkg::status_t status;
    logic [7:0]  tag;
    logic [15:0] cylinder;
    logic [4:0]  track;
    logic [4:0]  sector;
    logic        rd;
    logic [15:0] residual;
    logic [4:0]  qcount;
  } outcome_t;

  // Queue model and expected-outcome store
  class queue_scoreboard;
    logic [47:0] slice_reg [8];
    logic [15:0] e_cyl [DEPTH];
    logic [4:0]  e_trk [DEPTH];
    logic [4:0]  e_sec [DEPTH];
    logic        e_rd  [DEPTH];
    logic [7:0]  e_tag [DEPTH];
    int          e_nxt [DEPTH];
    bit          in_use [DEPTH];
    int          head, tail, scan;
    logic [2:0]  accepted;
    int          pending;
    outcome_t    expected_q[$];
    int          errors, checked;

    function new();
      for (int i = 0; i < 8; i++) slice_reg[i] = '0;
      for (int i = 0; i < DEPTH; i++) begin
        in_use[i] = 0;
        e_nxt[i] = NIL;
      end
      head = NIL; tail = NIL; scan = NIL;
      accepted = 0; pending = 0; errors = 0; checked = 0;
    endfunction

    function void set_slice(int idx, logic [47:0] v);
      slice_reg[idx] = v;
    endfunction

    function int cyl_gap(logic [15:0] a, logic [15:0] b);
      return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Predict the outcome of one accepted beat
    function void note_request(request_t r);
      outcome_t o;
      logic [23:0] last;
      logic [15:0] offs;
      int unsigned rem, per_cyl;
      int n, ap, cp, g;
      o = '{dreq_pkg::ST_QUEUED, 8'd0, 16'd0, 5'd0, 5'd0, 1'b0, 16'd0, 5'd0};
      if (r.cmd == dreq_pkg::CMD_DEQ) begin
        if (head == NIL) begin
          o.status = dreq_pkg::ST_EMPTY;
        end else begin
          n = head;
          head = e_nxt[n];
          if (head == NIL) tail = NIL;
          if (scan == n) scan = head;
          in_use[n] = 0;
          pending--;
          o.status = dreq_pkg::ST_DEQUEUED; o.tag = e_tag[n]; o.cylinder = e_cyl[n];
          o.track = e_trk[n]; o.sector = e_sec[n]; o.rd = e_rd[n];
        end
      end else begin
        last = slice_reg[r.slice][23:0];
        offs = slice_reg[r.slice][47:32];
        per_cyl = SPT * TPC;
        o.tag = r.tag;
        n = NIL;
        for (int i = 0; i < DEPTH; i++)
          if (!in_use[i] && n == NIL) n = i;
        if (r.block[31] || r.block >= {8'd0, last}) begin
          if (!r.block[31] && r.block == {8'd0, last} && r.is_read) begin
            o.status = dreq_pkg::ST_END_READ; o.residual = r.byte_count;
          end else begin
            o.status = dreq_pkg::ST_RANGE;
          end
        end else if (n == NIL) begin
          o.status = dreq_pkg::ST_FULL;
        end else begin
          in_use[n] = 1;
          e_cyl[n] = 16'(r.block / per_cyl + offs);
          rem = r.block % per_cyl;
          e_trk[n] = 5'(rem / SPT);
          e_sec[n] = 5'(rem % SPT);
          e_rd[n] = r.is_read;
          e_tag[n] = r.tag;
          e_nxt[n] = NIL;
          accepted = accepted + 3'd1;
          if (head == NIL) begin
            head = n; tail = n; scan = n;
          end else begin
            if (accepted == 0) scan = tail;
            ap = (scan != NIL) ? scan : head;
            cp = e_nxt[ap];
            g = 0;
            while (cp != NIL && g < DEPTH) begin
              if (cyl_gap(e_cyl[ap], e_cyl[n]) < cyl_gap(e_cyl[ap], e_cyl[cp])) break;
              ap = cp;
              cp = e_nxt[ap];
              g++;
            end
            e_nxt[ap] = n;
            e_nxt[n] = cp;
            if (cp == NIL) tail = n;
          end
          pending++;
          o.status = dreq_pkg::ST_QUEUED; o.cylinder = e_cyl[n]; o.track = e_trk[n];
          o.sector = e_sec[n]; o.rd = r.is_read;
        end
      end
      o.qcount = 5'(pending);
      expected_q.push_back(o);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(outcome_t a);
      outcome_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result beat, status %0d", a.status);
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status || a.tag !== e.tag || a.cylinder !== e.cylinder ||
          a.track !== e.track || a.sector !== e.sector || a.rd !== e.rd ||
          a.residual !== e.residual || a.qcount !== e.qcount) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp st%0d tag%0h cyl%0d trk%0d sec%0d rd%0d res%0d q%0d",
                   e.status, e.tag, e.cylinder, e.track, e.sector, e.rd, e.residual,
                   e.qcount);
          $display("       got st%0d tag%0h cyl%0d trk%0d sec%0d rd%0d res%0d q%0d",
                   a.status, a.tag, a.cylinder, a.track, a.sector, a.rd, a.residual,
                   a.qcount);
        end
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_wdata;
  logic        in_valid, in_stall;
  logic        in_cmd, in_is_read;
  logic [2:0]  in_slice;
  logic signed [31:0] in_block;
  logic [7:0]  in_tag;
  logic [15:0] in_byte_count;
  logic        out_valid, out_stall;
  logic [2:0]  out_status;
  logic [7:0]  out_tag;
  logic [15:0] out_cylinder, out_residual;
  logic [4:0]  out_track, out_sector, out_queue_count;
  logic        out_read;

  queue_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int beats_sent;

  disk_request_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_slice(in_slice),
    .in_block(in_block), .in_is_read(in_is_read), .in_tag(in_tag),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_tag(out_tag), .out_cylinder(out_cylinder), .out_track(out_track),
    .out_sector(out_sector), .out_read(out_read), .out_residual(out_residual),
    .out_queue_count(out_queue_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stall, check each accepted result beat
  always @(posedge clk) begin
    outcome_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.status = dreq_pkg::status_t'(out_status); a.tag = out_tag;
      a.cylinder = out_cylinder;
      a.track = out_track; a.sector = out_sector; a.rd = out_read;
      a.residual = out_residual; a.qcount = out_queue_count;
      sb.check_result(a);
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_slice(int idx, logic [47:0] v);
    cfg_we <= 1; cfg_index <= idx[2:0]; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.set_slice(idx, v);
  endtask

  // Present one beat, hold it until accepted, then drop valid
  task automatic send_beat(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_cmd <= r.cmd; in_slice <= r.slice; in_block <= r.block;
    in_is_read <= r.is_read; in_tag <= r.tag; in_byte_count <= r.byte_count;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    beats_sent++;
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Wait for all predictions to drain, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic request_t make_req(logic cmd, logic [2:0] sl, logic [31:0] blk,
                                        logic rd, logic [7:0] tg, logic [15:0] bc);
    request_t r;
    r.cmd = cmd; r.slice = sl; r.block = blk; r.is_read = rd; r.tag = tg; r.byte_count = bc;
    return r;
  endfunction

  // Mostly valid blocks, some end reads and range errors
  function automatic request_t random_req(int deq_pct);
    request_t r;
    logic [23:0] last;
    int k;
    r = make_req($urandom_range(99) < deq_pct, 3'($urandom_range(7)), $urandom,
                 1'($urandom_range(1)), 8'($urandom_range(255)),
                 16'($urandom_range(65535)));
    last = sb.slice_reg[r.slice][23:0];
    k = $urandom_range(19);
    if (k < 15 && last != 0) r.block = $urandom_range(int'(last) - 1);
    else if (k < 17) r.block = {8'd0, last};
    return r;
  endfunction

  task automatic load_slices(int mode);
    logic [47:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = {16'($urandom), 8'($urandom), 24'($urandom_range(20000))};
        1: v = {16'hFFFF, 8'hFF, 24'hFFFFFF};
        2: v = {16'($urandom_range(3)), 8'h00, 24'($urandom_range(3000))};
        default: v = {$urandom, 16'($urandom)};
      endcase
      if (i == 0 && mode == 2) v = '0;
      write_slice(i, v);
    end
  endtask

  initial begin
    int phase_len;
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_valid = 0; in_cmd = 0; in_slice = 0; in_block = 0; in_is_read = 0;
    in_tag = 0; in_byte_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0; beats_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty dequeue, extremes, end read, range errors, wrap
    write_slice(0, {16'hFFFF, 8'hA5, 24'd1216});
    write_slice(1, {16'h0000, 8'h00, 24'hFFFFFF});
    send_beat(make_req(dreq_pkg::CMD_DEQ, 0, 0, 0, 0, 0));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'h8000_0000, 1, 8'hFF, 16'hFFFF));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'hFFFF_FFFF, 0, 8'h01, 16'h1234));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'd1216, 1, 8'h02, 16'hFFFF));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'd1216, 0, 8'h03, 16'hFFFF));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 1, 32'h7FFF_FFFF, 1, 8'h04, 16'h0));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'd1215, 1, 8'h05, 0));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 0, 32'd0, 0, 8'h06, 0));
    for (int i = 0; i < 12; i++)
      send_beat(make_req(dreq_pkg::CMD_ENQ, 1, 32'hFF_FFFE - i * 40000, i[0],
                         8'(16 + i), 0));
    send_beat(make_req(dreq_pkg::CMD_ENQ, 1, 32'd5, 1, 8'hEE, 16'd7));
    send_beat(make_req(dreq_pkg::CMD_DEQ, 0, 0, 0, 0, 0));
    drain();

    // Random phases over several slice settings and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      load_slices(ph % 4);
      phase_len = 128;
      for (int i = 0; i < phase_len; i++) begin
        send_beat(random_req((i % 64) < 32 ? 25 : 60));
        if (i == 60) drain();
      end
      drain();
    end

    $display("Summary: %0d beats sent, %0d results checked over 8 slice setups and 4 idle mixes",
             beats_sent, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("Mismatches: %0d, predictions left: %0d", sb.errors, sb.expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dreq_pkg.sv
rtl/dreq_ram.sv
rtl/dreq_dp.sv
rtl/dreq_ctrl.sv
rtl/disk_request_scheduler.sv
sim/disk_request_scheduler_tb.sv
